/* design/srsd_pkg.sv */
package srsd_pkg;

    localparam logic [7:0] LINE_FEED     = 8'h0A;
    localparam logic [7:0] CHAR_OFFSET   = 8'h30;
    localparam logic [7:0] CHAR_TOP      = 8'h6F;
    localparam int         BITS_PER_CHAR = 6;
    localparam int         VALUE_W       = 24;
    localparam logic [2:0] STAMP_CHARS   = 3'd4;
    localparam logic [2:0] LONG_CHARS    = 3'd3;
    localparam logic [2:0] SHORT_CHARS   = 3'd2;

    typedef enum logic [1:0] {
        KIND_STAMP = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_END   = 2'd2
    } value_kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        value_kind_t        kind;
        logic               err;
    } result_t;

endpackage

/* design/srsd_decode.sv */
module srsd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic             cfg_write_data,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             start_of_data,
    output logic             emit,
    output srsd_pkg::result_t result
);
    import srsd_pkg::*;

    logic               short_reg;
    logic [7:0]         held_byte_reg, held_byte_next;
    logic               held_valid_reg, held_valid_next;
    logic               prior_lf_reg, prior_lf_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               ts_done_reg, ts_done_next;
    logic               err_reg, err_next;

    logic               e_held_valid, e_prior_lf, e_ts_done, e_err;
    logic [VALUE_W-1:0] e_acc;
    logic [2:0]         e_cnt;
    logic [7:0]         digit;
    logic [VALUE_W-1:0] acc_shift;
    logic [2:0]         cnt_inc;
    logic [2:0]         need;
    logic               bad_char;

    // start_of_data clears the decoder before the byte is taken
    assign e_held_valid = start_of_data ? 1'b0 : held_valid_reg;
    assign e_prior_lf   = start_of_data ? 1'b0 : prior_lf_reg;
    assign e_ts_done    = start_of_data ? 1'b0 : ts_done_reg;
    assign e_err        = start_of_data ? 1'b0 : err_reg;
    assign e_acc        = start_of_data ? '0 : acc_reg;
    assign e_cnt        = start_of_data ? 3'd0 : cnt_reg;

    assign digit     = held_byte_reg - CHAR_OFFSET;
    assign acc_shift = {e_acc[VALUE_W-BITS_PER_CHAR-1:0], digit[BITS_PER_CHAR-1:0]};
    assign cnt_inc   = e_cnt + 3'd1;
    assign bad_char  = (held_byte_reg < CHAR_OFFSET) || (held_byte_reg > CHAR_TOP);
    assign need      = !e_ts_done ? STAMP_CHARS : (short_reg ? SHORT_CHARS : LONG_CHARS);

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = e_held_valid;
        prior_lf_next   = e_prior_lf;
        acc_next        = e_acc;
        cnt_next        = e_cnt;
        ts_done_next    = e_ts_done;
        err_next        = e_err;
        emit            = 1'b0;
        result.value    = acc_shift;
        result.kind     = e_ts_done ? KIND_RANGE : KIND_STAMP;
        result.err      = e_err | bad_char;
        if (data_byte == LINE_FEED)
        begin
            priority if (e_held_valid)
            begin
                held_valid_next = 1'b0;
                prior_lf_next   = 1'b1;
            end
            else if (e_prior_lf)
            begin
                acc_next      = '0;
                cnt_next      = 3'd0;
                err_next      = 1'b0;
                prior_lf_next = 1'b0;
                emit          = 1'b1;
                result.value  = '0;
                result.kind   = KIND_END;
                result.err    = 1'b0;
            end
            else
            begin
                prior_lf_next = 1'b1;
            end
        end
        else
        begin
            if (e_held_valid)
            begin
                if (cnt_inc >= need)
                begin
                    emit         = 1'b1;
                    ts_done_next = 1'b1;
                    acc_next     = '0;
                    cnt_next     = 3'd0;
                    err_next     = 1'b0;
                end
                else
                begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    err_next = e_err | bad_char;
                end
            end
            held_byte_next  = data_byte;
            held_valid_next = 1'b1;
            prior_lf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg      <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            prior_lf_reg   <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= 3'd0;
            ts_done_reg    <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                short_reg <= cfg_write_data;
            end
            if (take)
            begin
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                prior_lf_reg   <= prior_lf_next;
                acc_reg        <= acc_next;
                cnt_reg        <= cnt_next;
                ts_done_reg    <= ts_done_next;
                err_reg        <= err_next;
            end
        end
    end

endmodule

/* design/srsd_out_queue.sv */
module srsd_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  srsd_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output srsd_pkg::result_t out_data,
    output logic [1:0]        fill
);
    import srsd_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign fill      = count_reg;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/sixbit_range_scan_decoder_unit.sv */
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | data_byte[7:0], start_of_data
// output   | out_valid / out_ready| decoded_value[23:0], value_kind[1:0],
//          |                      | char_error
// config   | cfg_write_en         | cfg_write_data (short_encoding)
//
// One byte per cycle while in_ready. A result is queued with the next non-line-feed
// byte after the group's last character (or second line feed) and leaves in turn.
// A two-entry result queue separates the sides; in_ready drops only when full.
// Reset clears all decoder state and short_encoding to zero.
module sixbit_range_scan_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] decoded_value,
    output logic [1:0]  value_kind,
    output logic        char_error
);
    import srsd_pkg::*;

    logic       take;
    logic       emit;
    logic       full;
    logic [1:0] fill;
    result_t    dec_result;
    result_t    q_result;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    srsd_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .take           (take),
        .data_byte      (data_byte),
        .start_of_data  (start_of_data),
        .emit           (emit),
        .result         (dec_result)
    );

    srsd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && emit),
        .push_data (dec_result),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (q_result),
        .fill      (fill)
    );

    assign decoded_value = q_result.value;
    assign value_kind    = q_result.kind;
    assign char_error    = q_result.err;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill != 2'd3)
        else $error("result queue overfilled");

    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_end_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && value_kind == KIND_END) |-> (decoded_value == '0 && !char_error))
        else $error("end marker carries data");
`endif

endmodule
